// ----- rtl/efbr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efbr_pkg: shared types and constants of the exact-fit block recycler
// Widths, action and status codes, and the queue word between the two parts.
// ----------------------------------------------------------------------------
package efbr_pkg;
    localparam int TableEntries = 64;
    localparam int IdxBits      = $clog2(TableEntries);
    localparam int CntBits      = $clog2(TableEntries + 1);
    localparam int AddrBits     = 32;
    localparam int TotalBits    = 40;

    localparam logic [2:0] ACT_ALLOC  = 3'd0;
    localparam logic [2:0] ACT_RECORD = 3'd1;
    localparam logic [2:0] ACT_FREE   = 3'd2;
    localparam logic [2:0] ACT_SIZE   = 3'd3;
    localparam logic [2:0] ACT_TOTALS = 3'd4;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_MISS     = 3'd1;
    localparam logic [2:0] ST_NOTFOUND = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_NULL     = 3'd4;

    typedef struct packed {
        logic [2:0]          action;
        logic                addr_null;
        logic [AddrBits-1:0] addr;
        logic [31:0]         size;
    } req_t;
endpackage

// ----- rtl/efbr_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efbr_front: request intake
// Accepts input words, classifies the null address and fills a small queue.
// ----------------------------------------------------------------------------
module efbr_front (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [2:0]                action,
    input  logic [31:0]               block_address,
    input  logic [31:0]               block_size,
    output logic                      q_valid,
    input  logic                      q_take,
    output efbr_pkg::req_t            q_word
);
    import efbr_pkg::*;

    req_t       q_mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push, pop;
    req_t       w;

    assign in_stall = (cnt_reg == 2'd2);
    assign push     = in_valid && !in_stall;
    assign q_valid  = (cnt_reg != 2'd0);
    assign pop      = q_valid && q_take;
    assign q_word   = q_mem_reg[rd_ptr_reg];

    always_comb
    begin
        w.action    = action;
        w.addr      = block_address[AddrBits-1:0];
        w.addr_null = (block_address[AddrBits-1:0] == '0);
        w.size      = block_size;
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= w;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end
endmodule

// ----- rtl/efbr_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efbr_back: table engine
// Scans the two tables one slot a cycle, updates them and drives the result.
// ----------------------------------------------------------------------------
module efbr_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_valid,
    output logic                  q_take,
    input  efbr_pkg::req_t        q_word,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [2:0]            status,
    output logic [31:0]           result_address,
    output logic [31:0]           result_size,
    output logic [39:0]           in_use_bytes,
    output logic [39:0]           free_bytes
);
    import efbr_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    // Entry memories: address and size per slot, read registered.
    logic [AddrBits-1:0] iu_addr_mem [TableEntries];
    logic [31:0]         iu_size_mem [TableEntries];
    logic [AddrBits-1:0] fr_addr_mem [TableEntries];
    logic [31:0]         fr_size_mem [TableEntries];
    logic [TableEntries-1:0] iu_valid_reg, fr_valid_reg;

    logic [1:0]          state_reg;
    req_t                req_reg;
    logic [CntBits-1:0]  idx_reg;
    logic [IdxBits-1:0]  rd_idx_reg;
    logic                rd_live_reg;
    logic [AddrBits-1:0] iu_addr_rd, fr_addr_rd;
    logic [31:0]         iu_size_rd, fr_size_rd;
    logic                hit_reg;
    logic [IdxBits-1:0]  hit_idx_reg;
    logic [AddrBits-1:0] hit_addr_reg;
    logic [31:0]         hit_size_reg;
    logic                iu_empty_ok_reg, fr_empty_ok_reg;
    logic [IdxBits-1:0]  iu_empty_reg, fr_empty_reg;
    logic [TotalBits-1:0] iu_tot_reg, fr_tot_reg;
    logic                out_valid_reg;
    logic [2:0]          status_reg;
    logic [31:0]         raddr_reg, rsize_reg;

    logic match;
    logic scan_alloc;
    logic [TotalBits-1:0] sz_ext;

    assign q_take     = (state_reg == S_IDLE) && q_valid;
    assign scan_alloc = (req_reg.action == ACT_ALLOC);
    assign match      = scan_alloc
                      ? (fr_valid_reg[rd_idx_reg] && fr_size_rd == req_reg.size)
                      : (iu_valid_reg[rd_idx_reg] && iu_addr_rd == req_reg.addr);
    assign sz_ext     = {{(TotalBits-32){1'b0}}, hit_size_reg};

    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign result_address = raddr_reg;
    assign result_size    = rsize_reg;
    assign in_use_bytes   = iu_tot_reg;
    assign free_bytes     = fr_tot_reg;

    always_ff @(posedge clk)
    begin
        iu_addr_rd <= iu_addr_mem[idx_reg[IdxBits-1:0]];
        iu_size_rd <= iu_size_mem[idx_reg[IdxBits-1:0]];
        fr_addr_rd <= fr_addr_mem[idx_reg[IdxBits-1:0]];
        fr_size_rd <= fr_size_mem[idx_reg[IdxBits-1:0]];
        if (state_reg == S_DONE && hit_reg && req_reg.action == ACT_ALLOC
            && iu_empty_ok_reg)
        begin
            iu_addr_mem[iu_empty_reg] <= hit_addr_reg;
            iu_size_mem[iu_empty_reg] <= hit_size_reg;
        end
        else if (state_reg == S_DONE && req_reg.action == ACT_RECORD
                 && !req_reg.addr_null && iu_empty_ok_reg)
        begin
            iu_addr_mem[iu_empty_reg] <= req_reg.addr;
            iu_size_mem[iu_empty_reg] <= req_reg.size;
        end
        if (state_reg == S_DONE && hit_reg && req_reg.action == ACT_FREE
            && fr_empty_ok_reg)
        begin
            fr_addr_mem[fr_empty_reg] <= hit_addr_reg;
            fr_size_mem[fr_empty_reg] <= hit_size_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_take)
        begin
            req_reg <= q_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            idx_reg         <= '0;
            rd_idx_reg      <= '0;
            rd_live_reg     <= 1'b0;
            hit_reg         <= 1'b0;
            hit_idx_reg     <= '0;
            hit_addr_reg    <= '0;
            hit_size_reg    <= '0;
            iu_empty_ok_reg <= 1'b0;
            fr_empty_ok_reg <= 1'b0;
            iu_empty_reg    <= '0;
            fr_empty_reg    <= '0;
            iu_valid_reg    <= '0;
            fr_valid_reg    <= '0;
            iu_tot_reg      <= '0;
            fr_tot_reg      <= '0;
            out_valid_reg   <= 1'b0;
            status_reg      <= ST_OK;
            raddr_reg       <= '0;
            rsize_reg       <= '0;
        end
        else
        begin
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (q_take)
                    begin
                        state_reg       <= S_SCAN;
                        idx_reg         <= '0;
                        rd_live_reg     <= 1'b0;
                        hit_reg         <= 1'b0;
                        iu_empty_ok_reg <= 1'b0;
                        fr_empty_ok_reg <= 1'b0;
                    end
                end
                S_SCAN:
                begin
                    // Address the next slot while checking the one read last cycle.
                    if (idx_reg != CntBits'(TableEntries))
                    begin
                        rd_idx_reg  <= idx_reg[IdxBits-1:0];
                        idx_reg     <= idx_reg + 1'b1;
                        rd_live_reg <= 1'b1;
                        if (!iu_empty_ok_reg && !iu_valid_reg[idx_reg[IdxBits-1:0]])
                        begin
                            iu_empty_ok_reg <= 1'b1;
                            iu_empty_reg    <= idx_reg[IdxBits-1:0];
                        end
                        if (!fr_empty_ok_reg && !fr_valid_reg[idx_reg[IdxBits-1:0]])
                        begin
                            fr_empty_ok_reg <= 1'b1;
                            fr_empty_reg    <= idx_reg[IdxBits-1:0];
                        end
                    end
                    else
                    begin
                        rd_live_reg <= 1'b0;
                    end
                    if (rd_live_reg && !hit_reg && match)
                    begin
                        hit_reg      <= 1'b1;
                        hit_idx_reg  <= rd_idx_reg;
                        hit_addr_reg <= scan_alloc ? fr_addr_rd : iu_addr_rd;
                        hit_size_reg <= scan_alloc ? fr_size_rd : iu_size_rd;
                    end
                    if (idx_reg == CntBits'(TableEntries) && !rd_live_reg)
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    raddr_reg  <= '0;
                    rsize_reg  <= '0;
                    status_reg <= ST_OK;
                    case (req_reg.action)
                        ACT_ALLOC:
                        begin
                            if (!hit_reg)
                            begin
                                status_reg <= ST_MISS;
                            end
                            else if (!iu_empty_ok_reg)
                            begin
                                status_reg <= ST_FULL;
                            end
                            else
                            begin
                                iu_valid_reg[iu_empty_reg] <= 1'b1;
                                fr_valid_reg[hit_idx_reg]  <= 1'b0;
                                iu_tot_reg <= iu_tot_reg + sz_ext;
                                fr_tot_reg <= fr_tot_reg - sz_ext;
                                raddr_reg  <= 32'(hit_addr_reg);
                            end
                        end
                        ACT_RECORD:
                        begin
                            if (req_reg.addr_null)
                            begin
                                status_reg <= ST_NULL;
                            end
                            else if (!iu_empty_ok_reg)
                            begin
                                status_reg <= ST_FULL;
                            end
                            else
                            begin
                                iu_valid_reg[iu_empty_reg] <= 1'b1;
                                iu_tot_reg <= iu_tot_reg
                                            + {{(TotalBits-32){1'b0}}, req_reg.size};
                            end
                        end
                        ACT_FREE:
                        begin
                            if (req_reg.addr_null)
                            begin
                                status_reg <= ST_NULL;
                            end
                            else if (!hit_reg)
                            begin
                                status_reg <= ST_NOTFOUND;
                            end
                            else if (!fr_empty_ok_reg)
                            begin
                                status_reg <= ST_FULL;
                            end
                            else
                            begin
                                fr_valid_reg[fr_empty_reg] <= 1'b1;
                                iu_valid_reg[hit_idx_reg]  <= 1'b0;
                                iu_tot_reg <= iu_tot_reg - sz_ext;
                                fr_tot_reg <= fr_tot_reg + sz_ext;
                            end
                        end
                        ACT_SIZE:
                        begin
                            if (req_reg.addr_null || !hit_reg)
                            begin
                                status_reg <= ST_NOTFOUND;
                            end
                            else
                            begin
                                rsize_reg <= hit_size_reg;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                    out_valid_reg <= 1'b1;
                    state_reg     <= S_OUT;
                end
                S_OUT:
                begin
                    if (!out_stall)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end
endmodule

// ----- rtl/exact_fit_block_recycler.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// exact_fit_block_recycler: exact-fit free list allocator
// Keeps in-use and free tables of address and size pairs with byte totals.
// ----------------------------------------------------------------------------
// Usage: request words enter on in_valid/in_stall with action, block_address
// and block_size. Each request gives exactly one result word on
// out_valid/out_stall carrying status, result_address, result_size and the
// two byte totals after the request.
// The front part takes requests into a two-word queue, so two requests can
// wait while the table engine works. The engine handles one request at a
// time: it walks all 64 slots of both tables, one slot a cycle through the
// registered entry memories, then commits. The sustained rate of result
// words is set by the slot-serial scan over the entry memories.
// Reset empties both tables by clearing their valid bits and zeroes the
// totals; no clearing pass is needed. When the receiver stalls, the result
// word holds and the engine waits; the queue then fills and in_stall rises.
// ----------------------------------------------------------------------------
module exact_fit_block_recycler (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  action,
    input  logic [31:0] block_address,
    input  logic [31:0] block_size,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status,
    output logic [31:0] result_address,
    output logic [31:0] result_size,
    output logic [39:0] in_use_bytes,
    output logic [39:0] free_bytes
);
    import efbr_pkg::*;

    logic q_valid;
    logic q_take;
    req_t q_word;

    // Front part: intake and queue.
    efbr_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .action        (action),
        .block_address (block_address),
        .block_size    (block_size),
        .q_valid       (q_valid),
        .q_take        (q_take),
        .q_word        (q_word)
    );

    // Back part: table scan, update and result register.
    efbr_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_valid        (q_valid),
        .q_take         (q_take),
        .q_word         (q_word),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .result_address (result_address),
        .result_size    (result_size),
        .in_use_bytes   (in_use_bytes),
        .free_bytes     (free_bytes)
    );
endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the exact-fit block recycler
// Drives request words through the valid/stall handshake, keeps its own copy
// of the in-use and free tables to predict every result word, and compares
// each result word, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
    import efbr_pkg::*;

    localparam int Slots = 64;

    typedef struct {
        logic [2:0]  status;
        logic [31:0] address;
        logic [31:0] size;
        logic [39:0] used;
        logic [39:0] spare;
    } verdict_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [2:0]  action = ACT_TOTALS;
    logic [31:0] block_address = '0;
    logic [31:0] block_size = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [2:0]  status;
    logic [31:0] result_address;
    logic [31:0] result_size;
    logic [39:0] in_use_bytes;
    logic [39:0] free_bytes;

    // Idle percentages for each side; changed between phases.
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    // While set, the receiver holds off entirely (counted in its own process).
    bit          hold_off = 1'b0;

    int unsigned mismatches = 0;
    int unsigned idle_cycles = 0;
    bit          timed_out = 1'b0;

    // Shadow copy of the tables and totals in the block.
    logic [31:0] used_addr [Slots];
    logic [31:0] used_len  [Slots];
    bit          used_ok   [Slots];
    logic [31:0] spare_addr [Slots];
    logic [31:0] spare_len  [Slots];
    bit          spare_ok   [Slots];
    logic [39:0] used_sum = '0;
    logic [39:0] spare_sum = '0;

    verdict_t    pending_results [$];
    // Addresses known to be in use, so the stimulus can free and query them.
    logic [31:0] live_addrs [$];
    // Sizes currently sitting in the free table, to produce alloc hits.
    logic [31:0] spare_sizes [$];
    logic [31:0] next_addr = 32'h0000_1000;

    always #4 clk = ~clk;

    exact_fit_block_recycler DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .action         (action),
        .block_address  (block_address),
        .block_size     (block_size),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .result_address (result_address),
        .result_size    (result_size),
        .in_use_bytes   (in_use_bytes),
        .free_bytes     (free_bytes)
    );

    function automatic int lowest_empty(input bit ok [Slots]);
        for (int i = 0; i < Slots; i++)
            if (!ok[i])
                return i;
        return -1;
    endfunction

    // Works out the result word of one request and updates the shadow tables.
    function automatic verdict_t recycle_step(input logic [2:0] act,
                                              input logic [31:0] addr,
                                              input logic [31:0] len);
        verdict_t v;
        int src;
        int dst;
        v.status  = ST_OK;
        v.address = '0;
        v.size    = '0;
        src = -1;
        case (act)
            ACT_ALLOC:
            begin
                for (int i = 0; i < Slots && src < 0; i++)
                    if (spare_ok[i] && spare_len[i] == len)
                        src = i;
                if (src < 0)
                    v.status = ST_MISS;
                else
                begin
                    dst = lowest_empty(used_ok);
                    if (dst < 0)
                        v.status = ST_FULL;
                    else
                    begin
                        used_addr[dst] = spare_addr[src];
                        used_len[dst]  = spare_len[src];
                        used_ok[dst]   = 1'b1;
                        spare_ok[src]  = 1'b0;
                        used_sum  += {8'd0, len};
                        spare_sum -= {8'd0, len};
                        v.address = spare_addr[src];
                    end
                end
            end
            ACT_RECORD:
            begin
                if (addr == '0)
                    v.status = ST_NULL;
                else
                begin
                    dst = lowest_empty(used_ok);
                    if (dst < 0)
                        v.status = ST_FULL;
                    else
                    begin
                        used_addr[dst] = addr;
                        used_len[dst]  = len;
                        used_ok[dst]   = 1'b1;
                        used_sum += {8'd0, len};
                    end
                end
            end
            ACT_FREE:
            begin
                if (addr == '0)
                    v.status = ST_NULL;
                else
                begin
                    for (int i = 0; i < Slots && src < 0; i++)
                        if (used_ok[i] && used_addr[i] == addr)
                            src = i;
                    if (src < 0)
                        v.status = ST_NOTFOUND;
                    else
                    begin
                        dst = lowest_empty(spare_ok);
                        if (dst < 0)
                            v.status = ST_FULL;
                        else
                        begin
                            spare_addr[dst] = used_addr[src];
                            spare_len[dst]  = used_len[src];
                            spare_ok[dst]   = 1'b1;
                            used_ok[src]    = 1'b0;
                            used_sum  -= {8'd0, used_len[src]};
                            spare_sum += {8'd0, used_len[src]};
                        end
                    end
                end
            end
            ACT_SIZE:
            begin
                if (addr != '0)
                    for (int i = 0; i < Slots && src < 0; i++)
                        if (used_ok[i] && used_addr[i] == addr)
                            src = i;
                if (src < 0)
                    v.status = ST_NOTFOUND;
                else
                    v.size = used_len[src];
            end
            default:
            begin
            end
        endcase
        v.used  = used_sum;
        v.spare = spare_sum;
        return v;
    endfunction

    task automatic report_mismatch(input string what, input logic [39:0] got,
                                   input logic [39:0] want);
        $display("MISMATCH %s: got %0h, expected %0h at %0t", what, got, want, $time);
        mismatches++;
    endtask

    // Offers one request word, predicting its result when it is accepted.
    task automatic send_request(input logic [2:0] act, input logic [31:0] addr,
                                input logic [31:0] len);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        action        <= act;
        block_address <= addr;
        block_size    <= len;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_results.push_back(recycle_step(act, addr, len));
    endtask

    // Result checker: one word per edge with valid high and stall low.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $display("MISMATCH unexpected result word at %0t", $time);
                mismatches++;
            end
            else
            begin
                verdict_t w;
                w = pending_results.pop_front();
                if (status !== w.status)
                    report_mismatch("status", status, w.status);
                if (result_address !== w.address)
                    report_mismatch("result_address", result_address, w.address);
                if (result_size !== w.size)
                    report_mismatch("result_size", result_size, w.size);
                if (in_use_bytes !== w.used)
                    report_mismatch("in_use_bytes", in_use_bytes, w.used);
                if (free_bytes !== w.spare)
                    report_mismatch("free_bytes", free_bytes, w.spare);
            end
        end
    end

    // Receiver stall: random, or held high for a stretch when asked.
    always @(posedge clk)
    begin
        if (hold_off)
            out_stall <= 1'b1;
        else
            out_stall <= (recv_idle_pct != 0) && ($urandom_range(99) < recv_idle_pct);
    end

    // Watchdog: cycles with no accepted word on either side.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 2000)
            timed_out <= 1'b1;
    end

    // Random size, mostly drawn from a small set so that alloc hits happen often.
    function automatic logic [31:0] pick_size();
        case ($urandom_range(3))
            0: return 32'($urandom_range(8)) * 16;
            1: return $urandom();
            2: return 32'hFFFF_FFFF;
            default: return 32'($urandom_range(4)) + 1;
        endcase
    endfunction

    function automatic logic [31:0] fresh_addr();
        if ($urandom_range(9) == 0)
            return $urandom() | 32'h1;
        next_addr += 32'h40;
        return next_addr;
    endfunction

    // Remembers addresses and sizes as they move, from the prediction itself.
    task automatic track(input logic [2:0] act, input logic [31:0] addr,
                         input logic [31:0] len);
        int k;
        verdict_t v;
        send_request(act, addr, len);
        v = pending_results[$];
        if (act == ACT_RECORD && v.status == ST_OK)
            live_addrs.push_back(addr);
        if (act == ACT_ALLOC && v.status == ST_OK)
        begin
            live_addrs.push_back(v.address);
            foreach (spare_sizes[i])
                if (spare_sizes[i] == len)
                begin
                    spare_sizes.delete(i);
                    break;
                end
        end
        if (act == ACT_FREE && v.status == ST_OK)
        begin
            k = -1;
            foreach (live_addrs[i])
                if (k < 0 && live_addrs[i] == addr)
                    k = i;
            if (k >= 0)
            begin
                foreach (used_addr[i])
                    ;
                live_addrs.delete(k);
            end
            for (int i = 0; i < Slots; i++)
                if (spare_ok[i] && spare_addr[i] == addr)
                    spare_sizes.push_back(spare_len[i]);
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_results.size() != 0 && !timed_out)
            @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    // Extremes and special cases other than full tables.
    task automatic test_directed();
        track(ACT_ALLOC, 32'h0, 32'h10);            // miss on empty free table
        track(ACT_SIZE, 32'h0, 32'h0);              // size query of null
        track(ACT_FREE, 32'h0, 32'h0);              // free of null
        track(ACT_RECORD, 32'h0, 32'h20);           // record of null
        track(ACT_FREE, 32'h1234, 32'h0);           // free of unknown address
        track(ACT_RECORD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        track(ACT_RECORD, 32'h0000_0001, 32'h0);
        track(ACT_RECORD, 32'h5555_5554, 32'hAAAA_AAAA);
        track(ACT_SIZE, 32'hFFFF_FFFF, 32'h0);
        track(ACT_SIZE, 32'h0000_0001, 32'hFFFF_FFFF);
        track(ACT_FREE, 32'hFFFF_FFFF, 32'h0);
        track(ACT_FREE, 32'h0000_0001, 32'h0);
        track(ACT_TOTALS, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        track(ACT_ALLOC, 32'h0, 32'hFFFF_FFFF);     // exact-fit hit
        track(ACT_ALLOC, 32'h0, 32'h0);             // hit of size zero
        track(ACT_ALLOC, 32'h0, 32'h0);             // now a miss
        track(3'd5, 32'hAAAA_AAAA, 32'h5555_5555);  // unknown actions
        track(3'd6, 32'h0, 32'h0);
        track(3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        track(ACT_FREE, 32'h5555_5554, 32'h0);
        track(ACT_FREE, 32'h5555_5554, 32'h0);      // double free: not found
    endtask

    // Fills the in-use table past its end, frees all into the free table
    // (which fills too), then reaches each full status and drains back out.
    task automatic test_full_tables();
        logic [31:0] a;
        for (int i = 0; i < Slots + 3; i++)
            track(ACT_RECORD, fresh_addr(), 32'($urandom_range(3)) * 8);
        while (live_addrs.size() != 0)
        begin
            a = live_addrs[0];
            track(ACT_FREE, a, 32'h0);
            if (live_addrs.size() != 0 && live_addrs[0] == a)
                void'(live_addrs.pop_front());
        end
        // Free table is full; a few new blocks go in use and one is freed.
        for (int i = 0; i < 4; i++)
            track(ACT_RECORD, fresh_addr(), 32'h7);
        track(ACT_FREE, live_addrs[0], 32'h0);      // free table full
        // Exact-fit hits move free blocks back until the in-use table is full.
        for (int i = 0; i < Slots - 4 && spare_sizes.size() != 0; i++)
            track(ACT_ALLOC, 32'h0, spare_sizes[0]);
        if (spare_sizes.size() != 0)
            track(ACT_ALLOC, 32'h0, spare_sizes[0]); // hit but in-use full
        track(ACT_RECORD, fresh_addr(), 32'h1);     // in-use full on record
        // Return to a small working set.
        while (live_addrs.size() > 4 && !timed_out)
        begin
            a = live_addrs[0];
            track(ACT_FREE, a, 32'h0);
            if (live_addrs.size() != 0 && live_addrs[0] == a)
                void'(live_addrs.pop_front());
        end
        for (int i = 0; i < 10; i++)
            track(ACT_ALLOC, 32'h0, (i % 2 == 0) ? 32'h8 : 32'h10);
    endtask

    // Mostly alloc/miss/record/free life cycles with random content.
    task automatic test_random(input int unsigned count);
        logic [31:0] len;
        logic [31:0] a;
        verdict_t v;
        for (int unsigned n = 0; n < count && !timed_out; n++)
        begin
            case ($urandom_range(9))
                0, 1, 2:
                begin
                    if (spare_sizes.size() != 0 && $urandom_range(2) != 0)
                        len = spare_sizes[$urandom_range(spare_sizes.size() - 1)];
                    else
                        len = pick_size();
                    track(ACT_ALLOC, $urandom(), len);
                    v = pending_results[$];
                    if (v.status == ST_MISS)
                        track(ACT_RECORD, fresh_addr(), len);
                end
                3, 4, 5:
                begin
                    if (live_addrs.size() != 0 && $urandom_range(5) != 0)
                        a = live_addrs[$urandom_range(live_addrs.size() - 1)];
                    else
                        a = ($urandom_range(7) == 0) ? 32'h0 : $urandom();
                    track(ACT_FREE, a, $urandom());
                end
                6:
                begin
                    if (live_addrs.size() != 0 && $urandom_range(3) != 0)
                        a = live_addrs[$urandom_range(live_addrs.size() - 1)];
                    else
                        a = ($urandom_range(5) == 0) ? 32'h0 : $urandom();
                    track(ACT_SIZE, a, $urandom());
                end
                7:
                    track(ACT_RECORD, ($urandom_range(9) == 0) ? 32'h0 : fresh_addr(),
                          pick_size());
                8:
                    track(ACT_TOTALS, $urandom(), $urandom());
                default:
                    track(3'($urandom_range(7)), $urandom(), $urandom());
            endcase
        end
    endtask

    // Receiver holds off for a long stretch while requests keep coming.
    task automatic test_backpressure();
        fork
            begin
                hold_off = 1'b1;
                repeat (400) @(posedge clk);
                hold_off = 1'b0;
            end
            test_random(8);
        join
    endtask

    initial
    begin
        foreach (used_ok[i])
        begin
            used_ok[i]  = 1'b0;
            spare_ok[i] = 1'b0;
        end
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_full_tables();
        drain();

        send_idle_pct = 9;
        recv_idle_pct = 62;
        test_random(40);
        test_backpressure();
        send_idle_pct = 62;
        recv_idle_pct = 9;
        test_random(40);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(40);
        drain();

        if (timed_out)
            $display("end of test: mismatches");
        else if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // A stuck handshake ends the run from here.
    always @(posedge clk)
    begin
        if (timed_out)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end
endmodule
